// ===== hdl/dstr_pkg.sv =====
// Shared types, constants and address helpers for the two-layer tilemap renderer.
// Every other file of the block imports this package; it depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dstr_pkg;

  // Plane and tile geometry. Both sizes are powers of two.
  localparam int PLANE_SIZE = 512;
  localparam int TILE_COUNT = 16384;
  localparam int PLANE_W    = $clog2(PLANE_SIZE);
  localparam int TCODE_W    = $clog2(TILE_COUNT);

  // Field widths of the request and pixel channels.
  localparam int REQ_TYPE_W = 2;
  localparam int WADDR_W    = 20;
  localparam int WDATA_W    = 16;
  localparam int PIXEL_W    = 9;
  localparam int COLOR_W    = 8;
  localparam int NIBBLE_W   = 4;

  // Storage geometry.
  localparam int TRAM_AW    = 15;
  localparam int PAL_AW     = 11;
  localparam int PAL_W      = 12;
  localparam int PEN_AW     = 20;
  localparam int PEN_W      = 4;
  localparam int LINE_W     = 7;
  localparam int ATTR_FLIPX = 14;
  localparam int ATTR_FLIPY = 15;

  localparam logic [TRAM_AW-1:0] BG_BASE = 15'h0000;
  localparam logic [TRAM_AW-1:0] FG_BASE = 15'h4000;

  // Configuration port.
  localparam int SCROLL_W  = 16;
  localparam int APB_DW    = 32;
  localparam int CFG_AW    = 4;
  localparam int REG_IDX_W = 2;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_TILE   = 2'd0,
    REQ_PAL    = 2'd1,
    REQ_PEN    = 2'd2,
    REQ_RENDER = 2'd3
  } req_kind_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BG_X = 2'd0,
    REG_BG_Y = 2'd1,
    REG_FG_X = 2'd2,
    REG_FG_Y = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SCROLL_W-1:0] bg_scroll_x;
    logic [SCROLL_W-1:0] bg_scroll_y;
    logic [SCROLL_W-1:0] fg_scroll_x;
    logic [SCROLL_W-1:0] fg_scroll_y;
  } cfg_t;

  // One classified transaction: write target or render with plane positions.
  typedef struct packed {
    req_kind_t            kind;
    logic [WADDR_W-1:0]   waddr;
    logic [WDATA_W-1:0]   wdata;
    logic [PLANE_W-1:0]   bg_x;
    logic [PLANE_W-1:0]   bg_y;
    logic [PLANE_W-1:0]   fg_x;
    logic [PLANE_W-1:0]   fg_y;
  } queue_item_t;

  // Screen coordinate plus effective scroll, which is the negated raw word
  // taken modulo the plane size.
  function automatic logic [PLANE_W-1:0] plane_pos(input logic [PIXEL_W-1:0] pix,
                                                   input logic [SCROLL_W-1:0] raw);
    logic [PLANE_W-1:0] eff;
    eff = PLANE_W'(0) - raw[PLANE_W-1:0];
    return PLANE_W'(pix) + eff;
  endfunction

  // Tile RAM word of a tile's attribute; the code word follows it.
  function automatic logic [TRAM_AW-1:0] tile_addr(input logic [TRAM_AW-1:0] base,
                                                   input logic [PLANE_W-1:0] x,
                                                   input logic [PLANE_W-1:0] y);
    logic [2*(PLANE_W-3):0] off;
    off = {y[PLANE_W-1:3], x[PLANE_W-1:3], 1'b0};
    return base + TRAM_AW'(off);
  endfunction

  // Pen address: code, then flipped row and column inside the 8x8 tile.
  function automatic logic [PEN_AW-1:0] pen_addr(input logic flip_y,
                                                 input logic flip_x,
                                                 input logic [TCODE_W-1:0] code,
                                                 input logic [PLANE_W-1:0] x,
                                                 input logic [PLANE_W-1:0] y);
    logic [2:0] row;
    logic [2:0] col;
    row = y[2:0] ^ {3{flip_y}};
    col = x[2:0] ^ {3{flip_x}};
    return PEN_AW'({code, row, col});
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dstr_if.sv =====
// Valid/ready channel interfaces for request transactions and rendered pixels.
// Depends on dstr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dstr_req_if import dstr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [WADDR_W-1:0]    write_address;
  logic [WDATA_W-1:0]    write_data;
  logic [PIXEL_W-1:0]    pixel_x;
  logic [PIXEL_W-1:0]    pixel_y;

  modport source (output valid, req_type, write_address, write_data, pixel_x, pixel_y,
                  input ready);
  modport sink   (input valid, req_type, write_address, write_data, pixel_x, pixel_y,
                  output ready);
endinterface

interface dstr_pix_if import dstr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               fg_shown;

  modport source (output valid, red, green, blue, fg_shown, input ready);
  modport sink   (input valid, red, green, blue, fg_shown, output ready);
endinterface

`default_nettype wire

// ===== hdl/dual_scroll_tilemap_renderer_top.sv =====
// Top level of the two-layer scrolling tilemap renderer.
// A render goes through tile fetch, pen read, palette and result steps before
// its pixel is shown; the sequencer takes no other transaction until it is done,
// set by the dependent tile RAM, pen and palette reads; writes end when taken.
// Reset (rst, synchronous) clears the queue, the sequencer and the scroll
// registers; the tile RAM, palette and pen memories hold garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module dual_scroll_tilemap_renderer_top import dstr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  dstr_req_if.sink          req,
  dstr_pix_if.source        pix,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // The four raw scroll words, used by the front at acceptance. Software must
  // write them only while no render transaction is in flight; not enforced here.
  cfg_t        cfg;

  // Queue handshake between the front and back parts. The two-entry queue
  // lets the request side keep posting while the sequencer is busy.
  logic        q_valid;
  logic        q_ready;
  queue_item_t q_item;

  dstr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front: decodes the request type and adds each layer's effective scroll
  // to the screen position, so the back part starts fetching right away.
  dstr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  // Back: performs memory writes, or walks a render through attribute and
  // code fetch for both layers, the two pen reads, the palette lookup and
  // the output register. The foreground wins unless its pen is zero.
  dstr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .pix     (pix)
  );

endmodule

`default_nettype wire

// ===== hdl/dstr_cfg.sv =====
// APB-style register file holding the four raw scroll words.
// Depends on dstr_pkg for the register index codes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module dstr_cfg import dstr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     regs;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_BG_X: regs.bg_scroll_x <= pwdata[SCROLL_W-1:0];
        REG_BG_Y: regs.bg_scroll_y <= pwdata[SCROLL_W-1:0];
        REG_FG_X: regs.fg_scroll_x <= pwdata[SCROLL_W-1:0];
        REG_FG_Y: regs.fg_scroll_y <= pwdata[SCROLL_W-1:0];
        default: regs <= regs;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BG_X: prdata = APB_DW'(regs.bg_scroll_x);
      REG_BG_Y: prdata = APB_DW'(regs.bg_scroll_y);
      REG_FG_X: prdata = APB_DW'(regs.fg_scroll_x);
      REG_FG_Y: prdata = APB_DW'(regs.fg_scroll_y);
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/dstr_front.sv =====
// Front part: accepts request transactions, classifies them and computes the
// scrolled plane positions, then parks them in a two-entry queue. Uses dstr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dstr_front import dstr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  dstr_req_if.sink    req,
  input  cfg_t        cfg,
  output logic        q_valid,
  input  logic        q_ready,
  output queue_item_t q_item
);

  queue_item_t           entries [QUEUE_DEPTH];
  queue_item_t           incoming;
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;
  logic                  push;
  logic                  pop;

  // Render positions are computed here for every transaction; the back part
  // only looks at them for render items.
  always_comb begin
    incoming.kind  = req_kind_t'(req.req_type);
    incoming.waddr = req.write_address;
    incoming.wdata = req.write_data;
    incoming.bg_x  = plane_pos(req.pixel_x, cfg.bg_scroll_x);
    incoming.bg_y  = plane_pos(req.pixel_y, cfg.bg_scroll_y);
    incoming.fg_x  = plane_pos(req.pixel_x, cfg.fg_scroll_x);
    incoming.fg_y  = plane_pos(req.pixel_y, cfg.fg_scroll_y);
  end

  assign req.ready = (count != QUEUE_CW'(QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != '0);
  assign pop       = q_valid && q_ready;
  assign q_item    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dstr_back.sv =====
// Back part: executes queued transactions. Holds tile RAM, palette and pen
// memories and the render sequencer with its output register. Uses dstr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dstr_back import dstr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  queue_item_t q_item,
  dstr_pix_if.source  pix
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TILE_BG,
    ST_TILE_FG,
    ST_PEN,
    ST_PAL,
    ST_RES
  } state_t;

  logic [WDATA_W-1:0] tile_ram [2**TRAM_AW];
  logic [PAL_W-1:0]   pal_ram  [2**PAL_AW];
  logic [PEN_W-1:0]   pen_ram  [2**PEN_AW];

  state_t              state;
  logic                pop;

  logic [PLANE_W-1:0]  bg_x;
  logic [PLANE_W-1:0]  bg_y;
  logic [PLANE_W-1:0]  fg_x;
  logic [PLANE_W-1:0]  fg_y;
  logic [LINE_W-1:0]   bg_line;
  logic                bg_flip_x;
  logic                bg_flip_y;
  logic [TCODE_W-1:0]  bg_code;
  logic [LINE_W-1:0]   fg_line;
  logic                shown;

  logic                out_valid;
  logic [COLOR_W-1:0]  out_red;
  logic [COLOR_W-1:0]  out_green;
  logic [COLOR_W-1:0]  out_blue;
  logic                out_fg_shown;

  logic                tram_we;
  logic                tram_re;
  logic [TRAM_AW-1:0]  tram_ra;
  logic [TRAM_AW-1:0]  tram_rb;
  logic [WDATA_W-1:0]  tram_rd_a;
  logic [WDATA_W-1:0]  tram_rd_b;

  logic                pal_we;
  logic                pal_re;
  logic [PAL_AW-1:0]   pal_ra;
  logic [PAL_W-1:0]    pal_rd;

  logic                pen_we;
  logic                pen_re;
  logic [PEN_AW-1:0]   pen_ra_bg;
  logic [PEN_AW-1:0]   pen_ra_fg;
  logic [PEN_W-1:0]    pen_rd_bg;
  logic [PEN_W-1:0]    pen_rd_fg;
  logic                fg_opaque;

  assign q_ready = (state == ST_IDLE);
  assign pop     = q_valid && q_ready;

  assign tram_we = pop && (q_item.kind == REQ_TILE);
  assign pal_we  = pop && (q_item.kind == REQ_PAL);
  assign pen_we  = pop && (q_item.kind == REQ_PEN);

  assign tram_re = (state == ST_TILE_BG) || (state == ST_TILE_FG);
  assign pen_re  = (state == ST_PEN);
  assign pal_re  = (state == ST_PAL);

  // Attribute word on port A, code word on port B of the same tile.
  always_comb begin
    if (state == ST_TILE_FG) begin
      tram_ra = tile_addr(FG_BASE, fg_x, fg_y);
    end else begin
      tram_ra = tile_addr(BG_BASE, bg_x, bg_y);
    end
    tram_rb = {tram_ra[TRAM_AW-1:1], 1'b1};
  end

  // The foreground tile words are still on the read registers in ST_PEN.
  assign pen_ra_bg = pen_addr(bg_flip_y, bg_flip_x, bg_code, bg_x, bg_y);
  assign pen_ra_fg = pen_addr(tram_rd_a[ATTR_FLIPY], tram_rd_a[ATTR_FLIPX],
                              tram_rd_b[TCODE_W-1:0], fg_x, fg_y);

  assign fg_opaque = (pen_rd_fg != '0);
  assign pal_ra    = fg_opaque ? {fg_line, pen_rd_fg} : {bg_line, pen_rd_bg};

  always_ff @(posedge clk) begin
    if (tram_we) begin
      tile_ram[q_item.waddr[TRAM_AW-1:0]] <= q_item.wdata;
    end
    if (tram_re) begin
      tram_rd_a <= tile_ram[tram_ra];
      tram_rd_b <= tile_ram[tram_rb];
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_ram[q_item.waddr[PAL_AW-1:0]] <= q_item.wdata[PAL_W-1:0];
    end
    if (pal_re) begin
      pal_rd <= pal_ram[pal_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pen_we) begin
      pen_ram[q_item.waddr[PEN_AW-1:0]] <= q_item.wdata[PEN_W-1:0];
    end
    if (pen_re) begin
      pen_rd_bg <= pen_ram[pen_ra_bg];
      pen_rd_fg <= pen_ram[pen_ra_fg];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the result step the output register is either reloaded or left
      // alone, so it is only cleared here outside that step.
      if (out_valid && pix.ready && (state != ST_RES)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop && (q_item.kind == REQ_RENDER)) begin
            bg_x  <= q_item.bg_x;
            bg_y  <= q_item.bg_y;
            fg_x  <= q_item.fg_x;
            fg_y  <= q_item.fg_y;
            state <= ST_TILE_BG;
          end
        end
        ST_TILE_BG: begin
          state <= ST_TILE_FG;
        end
        ST_TILE_FG: begin
          bg_line   <= tram_rd_a[LINE_W-1:0];
          bg_flip_x <= tram_rd_a[ATTR_FLIPX];
          bg_flip_y <= tram_rd_a[ATTR_FLIPY];
          bg_code   <= tram_rd_b[TCODE_W-1:0];
          state     <= ST_PEN;
        end
        ST_PEN: begin
          fg_line <= tram_rd_a[LINE_W-1:0];
          state   <= ST_PAL;
        end
        ST_PAL: begin
          shown <= fg_opaque;
          state <= ST_RES;
        end
        ST_RES: begin
          if (!out_valid || pix.ready) begin
            out_valid    <= 1'b1;
            out_red      <= {2{pal_rd[3*NIBBLE_W-1:2*NIBBLE_W]}};
            out_green    <= {2{pal_rd[2*NIBBLE_W-1:NIBBLE_W]}};
            out_blue     <= {2{pal_rd[NIBBLE_W-1:0]}};
            out_fg_shown <= shown;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign pix.valid    = out_valid;
  assign pix.red      = out_red;
  assign pix.green    = out_green;
  assign pix.blue     = out_blue;
  assign pix.fg_shown = out_fg_shown;

  // A render transaction starts the tile fetch in the next cycle.
  a_render_starts: assert property (@(posedge clk) disable iff (rst)
    (pop && (q_item.kind == REQ_RENDER)) |=> (state == ST_TILE_BG))
    else $error("render transaction did not start the tile fetch");

  // Write transactions finish in the cycle they are taken.
  a_write_single: assert property (@(posedge clk) disable iff (rst)
    (pop && (q_item.kind != REQ_RENDER)) |=> (state == ST_IDLE))
    else $error("write transaction left the sequencer busy");

  // The fetch steps run without gaps up to the palette lookup.
  a_fetch_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TILE_BG) |=> (state == ST_TILE_FG) ##1 (state == ST_PEN)
                              ##1 (state == ST_PAL))
    else $error("tile and pen fetch steps out of order");

  // A pixel is only ever presented from the result step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_RES))
    else $error("pixel presented outside the result step");

endmodule

`default_nettype wire
